// ===== src/rtc3w_pkg.sv =====
`default_nettype none

package rtc3w_pkg;

    localparam logic [5:0] FRAME_BITS = 6'd52;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_OPEN    = 3'd1;
    localparam logic [2:0] PH_PRESENT = 3'd2;
    localparam logic [2:0] PH_RISE    = 3'd3;
    localparam logic [2:0] PH_FALL    = 3'd4;
    localparam logic [2:0] PH_CLOSE   = 3'd5;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam int PIN_CE    = 0;
    localparam int PIN_WR    = 1;
    localparam int PIN_CLK   = 2;
    localparam int PIN_DOUT  = 3;
    localparam int PIN_DRIVE = 4;

    typedef struct packed {
        logic [1:0] action;
        logic       data_in;
        logic [6:0] set_seconds;
        logic [6:0] set_minutes;
        logic [6:0] set_hours;
        logic [3:0] set_weekday;
        logic [6:0] set_date;
        logic [6:0] set_month;
        logic [6:0] set_year;
    } rtc3w_cmd_t;

    typedef struct packed {
        logic [4:0] pins;
        logic       done_res;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [5:0] hours;
        logic [2:0] weekday;
        logic [5:0] date;
        logic [4:0] month;
        logic [7:0] year;
        logic       running;
    } rtc3w_res_t;

    typedef struct packed {
        logic [4:0]  pins;
        logic        done_res;
        logic [51:0] read_time;
    } rtc3w_step_t;

    // binary to BCD, v / 10 as (v * 205) >> 11
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        begin
            prod = 15'(v) * 15'd205;
            tens = prod[14:11];
            return 8'(8'(v) + 8'(tens) * 8'd6);
        end
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        begin
            return 8'(v - 8'(v[7:4]) * 8'd6);
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/rtc3w_encode.sv =====
`default_nettype none

module rtc3w_encode
    import rtc3w_pkg::*;
(
    input  wire rtc3w_cmd_t  cmd,
    output logic [51:0]      frame
);

    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hr_bcd;
    logic [7:0] wd_bcd;
    logic [7:0] date_bcd;
    logic [7:0] mon_bcd;
    logic [7:0] yr_bcd;

    always_comb
    begin
        sec_bcd  = to_bcd(cmd.set_seconds);
        min_bcd  = to_bcd(cmd.set_minutes);
        hr_bcd   = to_bcd(cmd.set_hours);
        wd_bcd   = to_bcd(7'(cmd.set_weekday));
        date_bcd = to_bcd(cmd.set_date);
        mon_bcd  = to_bcd(cmd.set_month);
        yr_bcd   = to_bcd(cmd.set_year);
        frame    = {yr_bcd, 1'b0, mon_bcd[6:0], date_bcd, wd_bcd[3:0],
                    hr_bcd, min_bcd, sec_bcd};
    end

endmodule

`default_nettype wire

// ===== src/rtc3w_format.sv =====
`default_nettype none

module rtc3w_format
    import rtc3w_pkg::*;
(
    input  wire rtc3w_step_t step,
    input  wire              output_binary,
    output rtc3w_res_t       res
);

    logic [7:0] sec_raw;
    logic [7:0] min_raw;
    logic [7:0] hr_raw;
    logic [7:0] wd_raw;
    logic [7:0] date_raw;
    logic [7:0] mon_raw;
    logic [7:0] yr_raw;
    logic [7:0] sec_v;
    logic [7:0] min_v;
    logic [7:0] hr_v;
    logic [7:0] wd_v;
    logic [7:0] date_v;
    logic [7:0] mon_v;
    logic [7:0] yr_v;

    always_comb
    begin
        sec_raw  = {1'b0, step.read_time[6:0]};
        min_raw  = {1'b0, step.read_time[14:8]};
        hr_raw   = {2'b0, step.read_time[21:16]};
        wd_raw   = {5'b0, step.read_time[26:24]};
        date_raw = {2'b0, step.read_time[33:28]};
        mon_raw  = {3'b0, step.read_time[40:36]};
        yr_raw   = step.read_time[51:44];

        sec_v  = output_binary ? from_bcd(sec_raw)  : sec_raw;
        min_v  = output_binary ? from_bcd(min_raw)  : min_raw;
        hr_v   = output_binary ? from_bcd(hr_raw)   : hr_raw;
        wd_v   = output_binary ? from_bcd(wd_raw)   : wd_raw;
        date_v = output_binary ? from_bcd(date_raw) : date_raw;
        mon_v  = output_binary ? from_bcd(mon_raw)  : mon_raw;
        yr_v   = output_binary ? from_bcd(yr_raw)   : yr_raw;

        res.pins     = step.pins;
        res.done_res = step.done_res;
        res.seconds  = sec_v[6:0];
        res.minutes  = min_v[6:0];
        res.hours    = hr_v[5:0];
        res.weekday  = wd_v[2:0];
        res.date     = date_v[5:0];
        res.month    = mon_v[4:0];
        res.year     = yr_v;
        res.running  = ~step.read_time[7];
    end

endmodule

`default_nettype wire

// ===== src/rtc3w_core.sv =====
`default_nettype none

module rtc3w_core
    import rtc3w_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              advance,
    input  wire rtc3w_cmd_t  cmd,
    output rtc3w_step_t      step
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic        is_write_reg;
    logic        is_write_next;
    logic [5:0]  bit_index_reg;
    logic [5:0]  bit_index_next;
    logic [51:0] frame_reg;
    logic [51:0] frame_next;
    logic [4:0]  pins_reg;
    logic [4:0]  pins_next;
    logic [51:0] read_time_reg;
    logic [51:0] read_time_next;
    logic        done;
    logic        busy;
    logic [51:0] enc_frame;

    rtc3w_encode u_encode
    (
        .cmd   (cmd),
        .frame (enc_frame)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        is_write_next  = is_write_reg;
        bit_index_next = bit_index_reg;
        frame_next     = frame_reg;
        pins_next      = pins_reg;
        read_time_next = read_time_reg;
        done           = 1'b0;
        busy           = phase_reg inside {[PH_OPEN:PH_CLOSE]};

        if (advance)
        begin
            if (cmd.action == ACT_READ || cmd.action == ACT_WRITE)
            begin
                if (!busy)
                begin
                    is_write_next  = (cmd.action == ACT_WRITE);
                    bit_index_next = '0;
                    phase_next     = PH_OPEN;
                    pins_next      = '0;
                    if (cmd.action == ACT_WRITE)
                    begin
                        frame_next            = enc_frame;
                        pins_next[PIN_WR]     = 1'b1;
                        pins_next[PIN_DRIVE]  = 1'b1;
                    end
                    else
                    begin
                        frame_next = '0;
                    end
                end
            end
            else if (cmd.action == ACT_TICK)
            begin
                case (phase_reg)
                    PH_OPEN:
                    begin
                        pins_next[PIN_CE] = 1'b1;
                        phase_next        = PH_PRESENT;
                    end
                    PH_PRESENT:
                    begin
                        pins_next[PIN_CLK]  = 1'b0;
                        pins_next[PIN_DOUT] = is_write_reg && (bit_index_reg < FRAME_BITS)
                                              && frame_reg[bit_index_reg];
                        phase_next          = PH_RISE;
                    end
                    PH_RISE:
                    begin
                        pins_next[PIN_CLK] = 1'b1;
                        phase_next         = PH_FALL;
                    end
                    PH_FALL:
                    begin
                        pins_next[PIN_CLK] = 1'b0;
                        if (!is_write_reg && (bit_index_reg < FRAME_BITS) && cmd.data_in)
                        begin
                            frame_next[bit_index_reg] = 1'b1;
                        end
                        bit_index_next = bit_index_reg + 6'd1;
                        phase_next     = (bit_index_next >= FRAME_BITS) ? PH_CLOSE : PH_PRESENT;
                    end
                    PH_CLOSE:
                    begin
                        pins_next = '0;
                        if (!is_write_reg)
                        begin
                            read_time_next = frame_reg;
                        end
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        step.pins      = pins_next;
        step.done_res  = done;
        step.read_time = read_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            is_write_reg  <= 1'b0;
            bit_index_reg <= '0;
            frame_reg     <= '0;
            pins_reg      <= '0;
            read_time_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            is_write_reg  <= is_write_next;
            bit_index_reg <= bit_index_next;
            frame_reg     <= frame_next;
            pins_reg      <= pins_next;
            read_time_reg <= read_time_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/three_wire_rtc_time_transfer.sv =====
// Channel  Direction  Handshake                  Payload
// command  in         cmd_valid / cmd_ready      cmd (rtc3w_cmd_t)
// result   out        res_valid / res_ready      res (rtc3w_res_t)
// config   in         cfg_we, no wait            cfg_data (output_binary)
//
// One result per command transfer; a command passes through the input register, then the result register.
// Sustained rate is one command per cycle while results are taken, set by the single pass of
// the sequencer between the two registers.
// Reset puts the sequencer idle, all pins low and not driving, read time zero.
// A stalled result holds; one further command is taken into the input register meanwhile.
`default_nettype none

module three_wire_rtc_time_transfer
    import rtc3w_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  wire rtc3w_cmd_t  cmd,
    output logic             res_valid,
    input  wire              res_ready,
    output rtc3w_res_t       res,
    input  wire              cfg_we,
    input  wire              cfg_data
);

    logic        in_valid_reg;
    logic        in_valid_next;
    rtc3w_cmd_t  in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    rtc3w_res_t  out_data_reg;
    logic        binary_reg;
    logic        advance;
    rtc3w_step_t step;
    rtc3w_res_t  res_next;

    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_valid && cmd_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rtc3w_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (in_data_reg),
        .step    (step)
    );

    rtc3w_format u_format
    (
        .step          (step),
        .output_binary (binary_reg),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            binary_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                binary_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            in_data_reg <= cmd;
        end
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("result register not loaded after advance");

    a_done_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> res.pins == 5'd0)
        else $error("pins not released at frame close");

    a_read_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.pins[PIN_WR] |-> !res.pins[PIN_DRIVE])
        else $error("data pin driven outside a write frame");

    a_clk_needs_ce: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.pins[PIN_CLK] |-> res.pins[PIN_CE])
        else $error("clock raised without chip enable");

endmodule

`default_nettype wire

// ===== verif/three_wire_rtc_time_transfer_test.sv =====
`timescale 1ns / 100ps

module three_wire_rtc_time_transfer_test;

    import rtc3w_pkg::*;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int HOLD_CYCLES = 300;

    localparam logic [45:0] SET_NONE = '0;
    localparam logic [45:0] SET_MAX  = {46{1'b1}};
    localparam logic [45:0] SET_99   = {7'd99, 7'd99, 7'd99, 4'd9, 7'd99, 7'd99, 7'd99};

    localparam logic [4:0]  PINS_LOW     = 5'd0;
    localparam logic [4:0]  PINS_WR_OPEN = 5'((1 << PIN_WR) | (1 << PIN_DRIVE));
    localparam logic [4:0]  PINS_WR_CE   = PINS_WR_OPEN | 5'(1 << PIN_CE);
    localparam logic [41:0] FIELDS_NONE  = '0;
    localparam logic [41:0] FIELDS_FULL  = {42{1'b1}};

    localparam rtc3w_res_t RES_QUIET   = {PINS_LOW, 1'b0, FIELDS_NONE, 1'b1};
    localparam rtc3w_res_t RES_WR_OPEN = {PINS_WR_OPEN, 1'b0, FIELDS_NONE, 1'b1};
    localparam rtc3w_res_t RES_WR_CE   = {PINS_WR_CE, 1'b0, FIELDS_NONE, 1'b1};
    localparam rtc3w_res_t RES_ALL_SET = {PINS_LOW, 1'b0, FIELDS_FULL, 1'b0};

    typedef struct {
        rtc3w_cmd_t cmd;
        bit         typed;
        bit         drain;
        rtc3w_res_t want;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    rtc3w_cmd_t cmd = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    rtc3w_res_t res;
    logic       cfg_we = 1'b0;
    logic       cfg_data = 1'b0;

    logic [2:0]  seq_ph = PH_IDLE;
    logic        seq_wr = 1'b0;
    logic [5:0]  seq_bit = '0;
    logic [51:0] seq_frame = '0;
    logic [4:0]  seq_pins = '0;
    logic [51:0] last_read = '0;
    logic        bin_out = 1'b0;

    rtc3w_res_t  pending_res[$];
    rtc3w_res_t  want_res;
    plan_row_t   plan[13];
    int          mismatches = 0;
    int          burst_left = 0;
    int unsigned hold_ask = 0;

    three_wire_rtc_time_transfer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] bcd_of(input logic [7:0] v);
        return 8'(v + 8'd6 * (v / 8'd10));
    endfunction

    function automatic logic [7:0] read_field(input logic [7:0] v);
        return bin_out ? 8'(v - 8'd6 * (v >> 4)) : v;
    endfunction

    function automatic rtc3w_res_t advance_link(input rtc3w_cmd_t c);
        rtc3w_res_t r;
        logic       busy;
        logic       done;
        logic [7:0] b_mon;
        logic [7:0] b_wd;
        busy = (seq_ph >= PH_OPEN) && (seq_ph <= PH_CLOSE);
        done = 1'b0;
        if (c.action == ACT_READ || c.action == ACT_WRITE)
        begin
            if (!busy)
            begin
                seq_wr = (c.action == ACT_WRITE);
                seq_bit = '0;
                seq_pins = '0;
                seq_frame = '0;
                if (seq_wr)
                begin
                    b_mon = bcd_of(c.set_month);
                    b_wd = bcd_of(c.set_weekday);
                    seq_frame = {bcd_of(c.set_year), 1'b0, b_mon[6:0], bcd_of(c.set_date),
                                 b_wd[3:0], bcd_of(c.set_hours), bcd_of(c.set_minutes),
                                 bcd_of(c.set_seconds)};
                    seq_pins[PIN_WR] = 1'b1;
                    seq_pins[PIN_DRIVE] = 1'b1;
                end
                seq_ph = PH_OPEN;
            end
        end
        else if (c.action == ACT_TICK)
        begin
            case (seq_ph)
                PH_OPEN:
                begin
                    seq_pins[PIN_CE] = 1'b1;
                    seq_ph = PH_PRESENT;
                end
                PH_PRESENT:
                begin
                    seq_pins[PIN_CLK] = 1'b0;
                    seq_pins[PIN_DOUT] = seq_wr && seq_frame[seq_bit];
                    seq_ph = PH_RISE;
                end
                PH_RISE:
                begin
                    seq_pins[PIN_CLK] = 1'b1;
                    seq_ph = PH_FALL;
                end
                PH_FALL:
                begin
                    seq_pins[PIN_CLK] = 1'b0;
                    if (!seq_wr && c.data_in)
                        seq_frame[seq_bit] = 1'b1;
                    seq_bit = seq_bit + 6'd1;
                    seq_ph = (seq_bit >= FRAME_BITS) ? PH_CLOSE : PH_PRESENT;
                end
                PH_CLOSE:
                begin
                    seq_pins = '0;
                    if (!seq_wr)
                        last_read = seq_frame;
                    done = 1'b1;
                    seq_ph = PH_IDLE;
                end
                default:
                    seq_ph = PH_IDLE;
            endcase
        end
        r.pins = seq_pins;
        r.done_res = done;
        r.seconds = 7'(read_field({1'b0, last_read[6:0]}));
        r.minutes = 7'(read_field({1'b0, last_read[14:8]}));
        r.hours = 6'(read_field({2'b0, last_read[21:16]}));
        r.weekday = 3'(read_field({5'b0, last_read[26:24]}));
        r.date = 6'(read_field({2'b0, last_read[33:28]}));
        r.month = 5'(read_field({3'b0, last_read[40:36]}));
        r.year = read_field(last_read[51:44]);
        r.running = ~last_read[7];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic offer_cmd(input rtc3w_cmd_t c, input bit typed, input rtc3w_res_t want);
        rtc3w_res_t guess;
        int         gap_len;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (!cmd_ready);
        guess = advance_link(c);
        pending_res.push_back(typed ? want : guess);
        burst_left--;
    endtask

    task automatic finish_frame(input logic din, input bit rnd);
        rtc3w_cmd_t c;
        while (seq_ph != PH_IDLE)
        begin
            c = rtc3w_cmd_t'(49'({$urandom, $urandom}));
            c.action = ACT_TICK;
            if (!rnd)
                c.data_in = din;
            offer_cmd(c, 1'b0, RES_QUIET);
        end
    endtask

    task automatic park_and_set(input logic v);
        finish_frame(1'b0, 1'b1);
        cmd_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bin_out = v;
        burst_left = 0;
    endtask

    task automatic random_phase(input int n, input bit squeeze);
        rtc3w_cmd_t c;
        int         taken;
        bit         busy;
        taken = 0;
        while (taken < n)
        begin
            c = rtc3w_cmd_t'(49'({$urandom, $urandom}));
            if ($urandom_range(1) == 0)
            begin
                c.set_seconds = 7'($urandom_range(99));
                c.set_minutes = 7'($urandom_range(99));
                c.set_hours = 7'($urandom_range(99));
                c.set_weekday = 4'($urandom_range(9));
                c.set_date = 7'($urandom_range(99));
                c.set_month = 7'($urandom_range(99));
                c.set_year = 7'($urandom_range(99));
            end
            busy = (seq_ph != PH_IDLE);
            if (busy)
            begin
                if ($urandom_range(99) < 94)
                    c.action = ACT_TICK;
                else
                    case ($urandom_range(2))
                        0: c.action = ACT_READ;
                        1: c.action = ACT_WRITE;
                        default: c.action = ACT_NOP;
                    endcase
            end
            else
                case ($urandom_range(9))
                    0, 1, 2, 3: c.action = ACT_READ;
                    4, 5, 6, 7: c.action = ACT_WRITE;
                    8: c.action = ACT_TICK;
                    default: c.action = ACT_NOP;
                endcase
            if (busy ? (c.action == ACT_TICK) : (c.action == ACT_READ || c.action == ACT_WRITE))
                taken++;
            if (squeeze && taken >= n / 2)
            begin
                hold_ask++;
                squeeze = 1'b0;
            end
            offer_cmd(c, 1'b0, RES_QUIET);
        end
    endtask

    initial
    begin : receiver
        int unsigned hold_seen;
        int unsigned pat_left;
        logic [7:0]  ready_pat;
        hold_seen = 0;
        pat_left = 0;
        ready_pat = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(16, 96);
                case ($urandom_range(2))
                    0: ready_pat = 8'hFF;
                    1: ready_pat = 8'($urandom) | 8'h01;
                    default: ready_pat = 8'h11;
                endcase
            end
            pat_left--;
            res_ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_res.size() == 0)
                flag_mismatch("result with nothing pending", res, 0);
            else
            begin
                want_res = pending_res.pop_front();
                if (res.pins !== want_res.pins)
                    flag_mismatch("pins", res.pins, want_res.pins);
                if (res.done_res !== want_res.done_res)
                    flag_mismatch("done_res", res.done_res, want_res.done_res);
                if (res.seconds !== want_res.seconds)
                    flag_mismatch("seconds", res.seconds, want_res.seconds);
                if (res.minutes !== want_res.minutes)
                    flag_mismatch("minutes", res.minutes, want_res.minutes);
                if (res.hours !== want_res.hours)
                    flag_mismatch("hours", res.hours, want_res.hours);
                if (res.weekday !== want_res.weekday)
                    flag_mismatch("weekday", res.weekday, want_res.weekday);
                if (res.date !== want_res.date)
                    flag_mismatch("date", res.date, want_res.date);
                if (res.month !== want_res.month)
                    flag_mismatch("month", res.month, want_res.month);
                if (res.year !== want_res.year)
                    flag_mismatch("year", res.year, want_res.year);
                if (res.running !== want_res.running)
                    flag_mismatch("running", res.running, want_res.running);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("** three_wire_rtc_time_transfer: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        plan[0]  = '{rtc3w_cmd_t'({ACT_TICK, 1'b1, SET_NONE}), 1'b1, 1'b0, RES_QUIET};
        plan[1]  = '{rtc3w_cmd_t'({ACT_NOP, 1'b1, SET_MAX}), 1'b1, 1'b0, RES_QUIET};
        plan[2]  = '{rtc3w_cmd_t'({ACT_WRITE, 1'b0, SET_MAX}), 1'b1, 1'b0, RES_WR_OPEN};
        plan[3]  = '{rtc3w_cmd_t'({ACT_READ, 1'b1, SET_NONE}), 1'b1, 1'b0, RES_WR_OPEN};
        plan[4]  = '{rtc3w_cmd_t'({ACT_WRITE, 1'b0, SET_NONE}), 1'b1, 1'b0, RES_WR_OPEN};
        plan[5]  = '{rtc3w_cmd_t'({ACT_NOP, 1'b0, SET_NONE}), 1'b1, 1'b0, RES_WR_OPEN};
        plan[6]  = '{rtc3w_cmd_t'({ACT_TICK, 1'b1, SET_NONE}), 1'b1, 1'b1, RES_WR_CE};
        plan[7]  = '{rtc3w_cmd_t'({ACT_READ, 1'b1, SET_MAX}), 1'b1, 1'b1, RES_QUIET};
        plan[8]  = '{rtc3w_cmd_t'({ACT_READ, 1'b0, SET_NONE}), 1'b1, 1'b1, RES_ALL_SET};
        plan[9]  = '{rtc3w_cmd_t'({ACT_TICK, 1'b0, SET_NONE}), 1'b1, 1'b0, RES_QUIET};
        plan[10] = '{rtc3w_cmd_t'({ACT_WRITE, 1'b1, SET_99}), 1'b1, 1'b1, RES_WR_OPEN};
        plan[11] = '{rtc3w_cmd_t'({ACT_WRITE, 1'b0, SET_NONE}), 1'b0, 1'b1, RES_QUIET};
        plan[12] = '{rtc3w_cmd_t'({ACT_NOP, 1'b1, SET_99}), 1'b0, 1'b0, RES_QUIET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        park_and_set(1'b0);

        for (i = 0; i < 13; i++)
        begin
            offer_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
            if (plan[i].drain)
                finish_frame(plan[i].cmd.data_in, 1'b0);
        end

        park_and_set(1'b1);
        random_phase(140, 1'b1);
        park_and_set(1'b0);
        random_phase(140, 1'b0);
        park_and_set(1'b1);
        random_phase(130, 1'b0);

        cmd_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("** three_wire_rtc_time_transfer: PASSED **");
        else
            $display("** three_wire_rtc_time_transfer: FAILED **");
        $finish;
    end

endmodule
